// ===== rtl/bee_pkg.sv =====
package bee_pkg;

  // Maximum number of open parentheses.
  localparam int NEST_DEPTH = 16;

  // Width of the nesting level, which counts from zero up to NEST_DEPTH.
  localparam int LEVEL_W = $clog2(NEST_DEPTH + 1);
  // Address width of the saved-frame store.
  localparam int ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  // Character codes.
  localparam logic [7:0] CH_EOL   = 8'h00;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_NOT   = 8'h7E;
  localparam logic [7:0] CH_AND   = 8'h5E;
  localparam logic [7:0] CH_OR    = 8'h76;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_OPERAND,
    PH_AFTER,
    PH_DASH,
    PH_SKIP
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_VALID    = 3'd0,
    ST_OPERAND  = 3'd1,
    ST_OPERATOR = 3'd2,
    ST_GT       = 3'd3,
    ST_DEEP     = 3'd4,
    ST_EARLY    = 3'd5,
    ST_TERM     = 3'd6
  } status_e;

  // Evaluation frame of one parenthesis level: pending negation and the
  // value/valid pairs of the AND term, the OR term and the implication chain.
  typedef struct packed {
    logic ik;
    logic iv;
    logic ok;
    logic ov;
    logic ak;
    logic av;
    logic neg;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  // One result item.
  typedef struct packed {
    status_e status;
    logic    value;
  } result_t;

  // Result handed from the parser to the output buffer.
  typedef struct packed {
    logic    vld;
    result_t res;
  } result_req_t;

  // Combine an operand into the AND term, applying a pending negation.
  function automatic frame_t take_operand(frame_t f, logic x);
    frame_t r;
    logic   xv;
    logic   a;
    xv    = x ^ f.neg;
    a     = f.ak ? (f.av & xv) : xv;
    r     = f;
    r.neg = 1'b0;
    r.ak  = 1'b1;
    r.av  = a;
    return r;
  endfunction

  // Fold the AND term into the OR term.
  function automatic frame_t close_and(frame_t f);
    frame_t r;
    logic   o;
    o    = f.ok ? (f.ov | f.av) : f.av;
    r    = f;
    r.av = 1'b0;
    r.ak = 1'b0;
    r.ok = 1'b1;
    r.ov = o;
    return r;
  endfunction

  // Fold the AND and OR terms into the implication chain.
  function automatic frame_t close_imply(frame_t f);
    frame_t r;
    logic   i;
    r    = close_and(f);
    i    = r.ik ? (~r.iv | r.ov) : r.ov;
    r.ov = 1'b0;
    r.ok = 1'b0;
    r.ik = 1'b1;
    r.iv = i;
    return r;
  endfunction

endpackage

// ===== rtl/bee_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module bee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bee_core.sv =====
// Parser and evaluator. The innermost enclosing frame sits in a register;
// the frames below it live in the frame memory. A pop reads the next frame
// from memory, and its data is used directly in the following cycle.
module bee_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           character_i,
  output bee_pkg::result_req_t result_o
);

  bee_pkg::frame_t             frame_q, frame_d;
  bee_pkg::frame_t             top_q, top_d;
  bee_pkg::frame_t             top_eff;
  logic                        top_sel_q, top_sel_d;
  logic [bee_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [bee_pkg::LEVEL_W-1:0] level_m1, level_m2;
  bee_pkg::phase_e             phase_q, phase_d;
  logic                        started_q, started_d;

  logic                        push;
  logic                        pop;
  logic                        ram_we;
  logic                        ram_re;
  logic [bee_pkg::FRAME_W-1:0] ram_rdata;
  bee_pkg::frame_t             fin;

  // Top of stack comes straight from memory in the cycle after a pop.
  assign top_eff  = top_sel_q ? bee_pkg::frame_t'(ram_rdata) : top_q;
  assign level_m1 = level_q - bee_pkg::LEVEL_W'(1);
  assign level_m2 = level_q - bee_pkg::LEVEL_W'(2);
  assign fin      = bee_pkg::close_imply(frame_q);

  // Spill the old top on a push when one exists; refill on a pop when the
  // level below the popped one is stored in memory.
  assign ram_we = push && (level_q != '0);
  assign ram_re = pop && (level_q > bee_pkg::LEVEL_W'(1));

  bee_ram #(
    .WIDTH (bee_pkg::FRAME_W),
    .DEPTH (bee_pkg::NEST_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (level_m1[bee_pkg::ADDR_W-1:0]),
    .wdata_i (top_eff),
    .re_i    (ram_re),
    .raddr_i (level_m2[bee_pkg::ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next-state and result logic for one character.
  always_comb begin
    frame_d        = frame_q;
    top_d          = top_eff;
    top_sel_d      = 1'b0;
    level_d        = level_q;
    phase_d        = phase_q;
    started_d      = started_q;
    push           = 1'b0;
    pop            = 1'b0;
    result_o.vld   = 1'b0;
    result_o.res.status = bee_pkg::ST_VALID;
    result_o.res.value  = 1'b0;

    if (accept_i) begin
      if (character_i == bee_pkg::CH_EOL) begin
        // End of line: report an unfinished expression, then start over.
        if ((phase_q != bee_pkg::PH_SKIP) && started_q) begin
          result_o.vld        = 1'b1;
          result_o.res.status = bee_pkg::ST_EARLY;
        end
        frame_d   = '0;
        level_d   = '0;
        phase_d   = bee_pkg::PH_OPERAND;
        started_d = 1'b0;
      end else if (phase_q != bee_pkg::PH_SKIP) begin
        started_d = 1'b1;
        unique case (phase_q)
          bee_pkg::PH_OPERAND: begin
            case (character_i) inside
              bee_pkg::CH_SPACE: begin
              end
              bee_pkg::CH_T, bee_pkg::CH_F: begin
                frame_d = bee_pkg::take_operand(frame_q, character_i == bee_pkg::CH_T);
                phase_d = bee_pkg::PH_AFTER;
              end
              bee_pkg::CH_NOT: begin
                frame_d.neg = ~frame_q.neg;
              end
              bee_pkg::CH_OPEN: begin
                if (level_q >= bee_pkg::LEVEL_W'(bee_pkg::NEST_DEPTH)) begin
                  result_o.vld        = 1'b1;
                  result_o.res.status = bee_pkg::ST_DEEP;
                end else begin
                  push    = 1'b1;
                  top_d   = frame_q;
                  level_d = level_q + bee_pkg::LEVEL_W'(1);
                  frame_d = '0;
                end
              end
              default: begin
                result_o.vld        = 1'b1;
                result_o.res.status = bee_pkg::ST_OPERAND;
              end
            endcase
          end
          bee_pkg::PH_DASH: begin
            if (character_i == bee_pkg::CH_GT) begin
              frame_d = bee_pkg::close_imply(frame_q);
              phase_d = bee_pkg::PH_OPERAND;
            end else begin
              result_o.vld        = 1'b1;
              result_o.res.status = bee_pkg::ST_GT;
            end
          end
          bee_pkg::PH_AFTER: begin
            case (character_i) inside
              bee_pkg::CH_SPACE: begin
              end
              bee_pkg::CH_AND: begin
                phase_d = bee_pkg::PH_OPERAND;
              end
              bee_pkg::CH_OR: begin
                frame_d = bee_pkg::close_and(frame_q);
                phase_d = bee_pkg::PH_OPERAND;
              end
              bee_pkg::CH_DASH: begin
                phase_d = bee_pkg::PH_DASH;
              end
              bee_pkg::CH_DOT: begin
                result_o.vld = 1'b1;
                if (level_q != '0) begin
                  result_o.res.status = bee_pkg::ST_TERM;
                end else begin
                  result_o.res.value = fin.iv;
                end
              end
              bee_pkg::CH_CLOSE: begin
                if (level_q == '0) begin
                  result_o.vld        = 1'b1;
                  result_o.res.status = bee_pkg::ST_TERM;
                end else begin
                  // Close the group and feed its value to the enclosing frame.
                  pop       = 1'b1;
                  top_sel_d = 1'b1;
                  level_d   = level_m1;
                  frame_d   = bee_pkg::take_operand(top_eff, fin.iv);
                  phase_d   = bee_pkg::PH_AFTER;
                end
              end
              default: begin
                result_o.vld        = 1'b1;
                result_o.res.status = bee_pkg::ST_OPERATOR;
              end
            endcase
          end
          default: begin
          end
        endcase
        if (result_o.vld) begin
          phase_d = bee_pkg::PH_SKIP;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '0;
      level_q   <= '0;
      phase_q   <= bee_pkg::PH_OPERAND;
      started_q <= 1'b0;
      top_sel_q <= 1'b0;
    end else begin
      frame_q   <= frame_d;
      level_q   <= level_d;
      phase_q   <= phase_d;
      started_q <= started_d;
      top_sel_q <= top_sel_d;
    end
  end

  // Cached top-of-stack frame.
  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

endmodule

// ===== rtl/bee_out_buf.sv =====
// Two-entry output buffer: an output register plus a skid entry, so the
// parser keeps taking characters while a result waits downstream.
module bee_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bee_pkg::result_req_t result_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bee_pkg::result_t     out_o
);

  logic             head_vld_q, head_vld_d;
  logic             skid_vld_q, skid_vld_d;
  bee_pkg::result_t head_q, head_d;
  bee_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop         = head_vld_q && out_ready_i;
  assign ready_o     = !skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign out_o       = head_q;

  // Advance the queue on a transfer and append a new result at the tail.
  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        head_vld_d = 1'b0;
      end
    end
    if (result_i.vld) begin
      if (!head_vld_d) begin
        head_d     = result_i.res;
        head_vld_d = 1'b1;
      end else begin
        skid_d     = result_i.res;
        skid_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

// ===== rtl/boolean_expression_evaluator.sv =====
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   character_i[7:0]
// out      output     out_valid_o / out_ready_i status_o[2:0], value_o
//
// One character is taken per cycle while in_ready_o is high.
// Each '(' or ')' does at most one write or one read of the frame memory, and
// a read result is used from the memory output in the next cycle.
// Reset clears the parser state; the frame memory needs no clearing.
// Input stalls only when both output entries hold untaken results.
module boolean_expression_evaluator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic       value_o
);

  bee_pkg::result_req_t result;
  bee_pkg::result_t     out_res;
  logic                 accept;

  assign accept = in_valid_i && in_ready_o;

  // Parser with the frame memory.
  bee_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .character_i (character_i),
    .result_o    (result)
  );

  // Output register and skid entry.
  bee_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign status_o = out_res.status;
  assign value_o  = out_res.value;

endmodule
